// ----- hdl/wcis_pkg.sv -----
// ----------------------------------------------------------------------------
// wcis_pkg
// Shared types and codes for the word cpu instruction step block.
// ----------------------------------------------------------------------------
`default_nettype none

package wcis_pkg;

  // default ram depth in words
  localparam int unsigned MEM_WORDS_DEF = 65536;

  // command codes
  localparam logic [2:0] CMD_WR_MEM = 3'd0;
  localparam logic [2:0] CMD_RD_MEM = 3'd1;
  localparam logic [2:0] CMD_EXEC   = 3'd2;
  localparam logic [2:0] CMD_WR_REG = 3'd3;
  localparam logic [2:0] CMD_RD_REG = 3'd4;

  // register indexes beyond the general registers
  localparam logic [3:0] RIDX_SP = 4'd8;
  localparam logic [3:0] RIDX_PC = 4'd9;
  localparam logic [3:0] RIDX_O  = 4'd10;

  // basic opcodes
  localparam logic [3:0] OP_NB  = 4'h0;
  localparam logic [3:0] OP_SET = 4'h1;
  localparam logic [3:0] OP_ADD = 4'h2;
  localparam logic [3:0] OP_SUB = 4'h3;
  localparam logic [3:0] OP_MUL = 4'h4;
  localparam logic [3:0] OP_DIV = 4'h5;
  localparam logic [3:0] OP_MOD = 4'h6;
  localparam logic [3:0] OP_SHL = 4'h7;
  localparam logic [3:0] OP_SHR = 4'h8;
  localparam logic [3:0] OP_AND = 4'h9;
  localparam logic [3:0] OP_BOR = 4'ha;
  localparam logic [3:0] OP_XOR = 4'hb;
  localparam logic [3:0] OP_IFE = 4'hc;
  localparam logic [3:0] OP_IFN = 4'hd;
  localparam logic [3:0] OP_IFG = 4'he;
  localparam logic [3:0] OP_IFB = 4'hf;

  // non-basic opcodes
  localparam logic [5:0] NB_JSR = 6'h01;
  localparam logic [5:0] NB_SYS = 6'h02;

  // operand codes with special meaning
  localparam logic [5:0] OPD_POP    = 6'h18;
  localparam logic [5:0] OPD_PEEK   = 6'h19;
  localparam logic [5:0] OPD_PUSH   = 6'h1a;
  localparam logic [5:0] OPD_SP     = 6'h1b;
  localparam logic [5:0] OPD_PC     = 6'h1c;
  localparam logic [5:0] OPD_O      = 6'h1d;
  localparam logic [5:0] OPD_NW_MEM = 6'h1e;
  localparam logic [5:0] OPD_NW_LIT = 6'h1f;

  typedef enum logic [2:0] {
    LOC_REG, LOC_MEM, LOC_SP, LOC_PC, LOC_O, LOC_LIT
  } loc_kind_t;

  typedef struct packed {
    loc_kind_t   kind;
    logic [15:0] idx;
  } loc_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEMRD, ST_INS, ST_RES, ST_NW, ST_VA, ST_VB, ST_OP, ST_DIV, ST_WB,
    ST_DONE
  } exec_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [3:0]  reg_index;
    logic [15:0] data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] prog_counter;
    logic [15:0] stack_ptr;
    logic [15:0] overflow_word;
    logic        halted;
    logic        will_skip;
    logic [2:0]  cycles_used;
    logic        bad_syscall;
  } out_item_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/wcis_front.sv -----
// ----------------------------------------------------------------------------
// wcis_front
// Command intake: two-entry queue that decouples the host from the core.
// ----------------------------------------------------------------------------
`default_nettype none

module wcis_front
  import wcis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  input  wire logic     q_pop,
  output q_ctl_t        q_ctl,
  output in_item_t      q_item
);

  in_item_t   ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy;
  assign pop    = q_pop && (cnt_r != 2'd0);
  assign q_item = ent_r[rd_ptr_r];

  always_comb begin
    q_ctl.valid = (cnt_r != 2'd0);
    q_ctl.pop   = pop;
  end

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wcis_back.sv -----
// ----------------------------------------------------------------------------
// wcis_back
// Execution core: ram, register file, operand sequencer and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module wcis_back
  import wcis_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_ctl_t   q_ctl,
  input  wire in_item_t q_item,
  output logic          q_pop,
  output logic          out_valid,
  output out_item_t     out_item
);

  localparam int unsigned AW    = $clog2(MEM_WORDS);
  localparam longint      RECIP = (64'd1 << 32) / MEM_WORDS;

  // address modulo ram depth by reciprocal multiply and one correction
  function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
    logic [47:0] p;
    logic [15:0] q;
    logic [32:0] qm;
    logic [32:0] r;
    p  = {32'd0, a} * {23'd0, RECIP[24:0]};
    q  = p[47:32];
    qm = {17'd0, q} * 33'(MEM_WORDS);
    r  = {17'd0, a} - qm;
    if (r >= 33'(MEM_WORDS)) begin
      r = r - 33'(MEM_WORDS);
    end
    return r[AW-1:0];
  endfunction

  function automatic logic needs_word(input logic [5:0] c);
    return (c[5:3] == 3'b010) || (c == OPD_NW_MEM) || (c == OPD_NW_LIT);
  endfunction

  // ram
  logic [15:0]   mem [MEM_WORDS];
  logic [15:0]   mem_q;
  logic          mem_we;
  logic [15:0]   mem_wa, mem_wd, mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_index(mem_wa)] <= mem_wd;
    end
    mem_q <= mem[mem_index(mem_ra)];
  end

  // architectural and sequencer state
  exec_state_t state_r, state_nxt;
  logic [15:0] gp_r [8];
  logic        gp_we;
  logic [2:0]  gp_wa, gp_ra;
  logic [15:0] gp_wd, gp_rd;
  logic [15:0] sp_r, sp_nxt, pc_r, pc_nxt, ovf_r, ovf_nxt;
  logic        skip_r, skip_nxt, halt_r, halt_nxt, bad_r, bad_nxt;
  logic [2:0]  cyc_r, cyc_nxt;
  logic [15:0] rd_r, rd_nxt;
  in_item_t    it_r, it_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [5:0]  ac_r, ac_nxt, bc_r, bc_nxt;
  logic        selb_r, selb_nxt;
  loc_t        la_r, la_nxt, lb_r, lb_nxt;
  logic [15:0] a_r, a_nxt, res_r, res_nxt, o_r, o_nxt;
  logic        wo_r, wo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;

  assign gp_rd = gp_r[gp_ra];

  // shared decode
  logic [5:0]  cur_code;
  logic        cur_nw;
  logic        res_last;
  logic [15:0] b_val;
  loc_t        loc_new;
  logic [15:0] sp_res;
  logic [15:0] nw_val;
  logic [16:0] rem_sh;

  assign cur_code = selb_r ? bc_r : ac_r;
  assign cur_nw   = needs_word(cur_code);
  assign res_last = selb_r;
  assign nw_val   = mem_q;
  assign rem_sh   = {rem_r[15:0], quo_r[31]};

  // register file read port address
  always_comb begin
    case (state_r)
      ST_IDLE:      gp_ra = q_item.reg_index[2:0];
      ST_RES, ST_NW: gp_ra = cur_code[2:0];
      ST_VB:        gp_ra = la_r.idx[2:0];
      default:      gp_ra = lb_r.idx[2:0];
    endcase
  end

  // operand location and stack pointer after resolving one operand
  always_comb begin
    loc_new.kind = LOC_LIT;
    loc_new.idx  = {11'd0, cur_code[4:0]};
    sp_res       = sp_r;
    if (cur_code[5:3] == 3'b000) begin
      loc_new.kind = LOC_REG;
      loc_new.idx  = {13'd0, cur_code[2:0]};
    end else if (cur_code[5:3] == 3'b001) begin
      loc_new.kind = LOC_MEM;
      loc_new.idx  = gp_rd;
    end else if (cur_code[5:3] == 3'b010) begin
      loc_new.kind = LOC_MEM;
      loc_new.idx  = nw_val + gp_rd;
    end else if (cur_code == OPD_POP) begin
      loc_new.kind = LOC_MEM;
      loc_new.idx  = sp_r;
      sp_res       = sp_r + 16'd1;
    end else if (cur_code == OPD_PEEK) begin
      loc_new.kind = LOC_MEM;
      loc_new.idx  = sp_r;
    end else if (cur_code == OPD_PUSH) begin
      loc_new.kind = LOC_MEM;
      loc_new.idx  = sp_r - 16'd1;
      sp_res       = sp_r - 16'd1;
    end else if (cur_code == OPD_SP) begin
      loc_new.kind = LOC_SP;
    end else if (cur_code == OPD_PC) begin
      loc_new.kind = LOC_PC;
    end else if (cur_code == OPD_O) begin
      loc_new.kind = LOC_O;
    end else if (cur_code == OPD_NW_MEM) begin
      loc_new.kind = LOC_MEM;
      loc_new.idx  = nw_val;
    end else if (cur_code == OPD_NW_LIT) begin
      loc_new.kind = LOC_LIT;
      loc_new.idx  = nw_val;
    end
  end

  // value of operand b, ram data from the read issued in ST_VB
  always_comb begin
    case (lb_r.kind)
      LOC_REG: b_val = gp_rd;
      LOC_MEM: b_val = mem_q;
      LOC_SP:  b_val = sp_r;
      LOC_PC:  b_val = pc_r;
      LOC_O:   b_val = ovf_r;
      default: b_val = lb_r.idx;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_ctl.valid) begin
          if (q_item.cmd == CMD_RD_MEM) state_nxt = ST_MEMRD;
          else if (q_item.cmd == CMD_EXEC) state_nxt = ST_INS;
          else state_nxt = ST_DONE;
        end
      end
      ST_MEMRD: state_nxt = ST_DONE;
      ST_INS:   state_nxt = ST_RES;
      ST_RES: begin
        if (cur_nw) state_nxt = ST_NW;
        else if (res_last) state_nxt = skip_r ? ST_DONE : ST_VA;
      end
      ST_NW: begin
        if (!res_last) state_nxt = ST_RES;
        else state_nxt = skip_r ? ST_DONE : ST_VA;
      end
      ST_VA: state_nxt = ST_VB;
      ST_VB: state_nxt = ST_OP;
      ST_OP: begin
        if (op_r == OP_NB || op_r == OP_IFE || op_r == OP_IFN || op_r == OP_IFG ||
            op_r == OP_IFB) begin
          state_nxt = ST_DONE;
        end else if ((op_r == OP_DIV || op_r == OP_MOD) && b_val != 16'd0) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_DIV:  if (dcnt_r == 5'd31) state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [16:0] sum;
    logic [31:0] prod;
    logic [47:0] shl;
    logic [31:0] shr;
    logic        t;
    logic        big;
    sp_nxt   = sp_r;    pc_nxt  = pc_r;    ovf_nxt = ovf_r;
    skip_nxt = skip_r;  halt_nxt = halt_r; bad_nxt = bad_r;
    cyc_nxt  = cyc_r;   rd_nxt  = rd_r;    it_nxt  = it_r;
    op_nxt   = op_r;    ac_nxt  = ac_r;    bc_nxt  = bc_r;
    selb_nxt = selb_r;  la_nxt  = la_r;    lb_nxt  = lb_r;
    a_nxt    = a_r;     res_nxt = res_r;   o_nxt   = o_r;   wo_nxt = wo_r;
    rem_nxt  = rem_r;   quo_nxt = quo_r;   dvs_nxt = dvs_r; dcnt_nxt = dcnt_r;
    mem_we = 1'b0; mem_wa = it_r.address; mem_wd = it_r.data; mem_ra = pc_r;
    gp_we  = 1'b0; gp_wa  = it_r.reg_index[2:0]; gp_wd = it_r.data;
    q_pop  = 1'b0;
    sum  = {1'b0, a_r} + {1'b0, b_val};
    prod = a_r * b_val;
    big  = (b_val[15:5] != 11'd0);
    shl  = {32'd0, a_r} << b_val[4:0];
    shr  = {a_r, 16'd0} >> b_val[4:0];
    t    = 1'b0;
    case (state_r)
      // take the next command from the queue
      ST_IDLE: begin
        if (q_ctl.valid) begin
          q_pop   = 1'b1;
          it_nxt  = q_item;
          rd_nxt  = 16'd0;
          cyc_nxt = 3'd0;
          bad_nxt = 1'b0;
          mem_ra  = (q_item.cmd == CMD_RD_MEM) ? q_item.address : pc_r;
          case (q_item.cmd)
            CMD_WR_MEM: begin
              mem_we = 1'b1;
              mem_wa = q_item.address;
              mem_wd = q_item.data;
            end
            CMD_WR_REG: begin
              if (q_item.reg_index[3] == 1'b0) begin
                gp_we = 1'b1;
                gp_wa = q_item.reg_index[2:0];
                gp_wd = q_item.data;
              end else if (q_item.reg_index == RIDX_SP) sp_nxt = q_item.data;
              else if (q_item.reg_index == RIDX_PC) pc_nxt = q_item.data;
              else if (q_item.reg_index == RIDX_O) ovf_nxt = q_item.data;
            end
            CMD_RD_REG: begin
              if (q_item.reg_index[3] == 1'b0) rd_nxt = gp_rd;
              else if (q_item.reg_index == RIDX_SP) rd_nxt = sp_r;
              else if (q_item.reg_index == RIDX_PC) rd_nxt = pc_r;
              else if (q_item.reg_index == RIDX_O) rd_nxt = ovf_r;
            end
            default: ;
          endcase
        end
      end
      ST_MEMRD: rd_nxt = mem_q;
      // split the instruction word
      ST_INS: begin
        op_nxt   = mem_q[3:0];
        ac_nxt   = mem_q[9:4];
        bc_nxt   = mem_q[15:10];
        selb_nxt = (mem_q[3:0] == OP_NB);
        pc_nxt   = pc_r + 16'd1;
        la_nxt.kind = LOC_LIT;
        la_nxt.idx  = {10'd0, mem_q[9:4]};
      end
      // resolve an operand, fetching its extra word if it has one
      ST_RES: begin
        if (cur_nw) begin
          mem_ra  = pc_r;
          pc_nxt  = pc_r + 16'd1;
          cyc_nxt = cyc_r + 3'd1;
        end else begin
          sp_nxt = sp_res;
          if (selb_r) lb_nxt = loc_new;
          else la_nxt = loc_new;
          selb_nxt = 1'b1;
          if (res_last && skip_r) skip_nxt = 1'b0;
        end
      end
      ST_NW: begin
        sp_nxt = sp_res;
        if (selb_r) lb_nxt = loc_new;
        else la_nxt = loc_new;
        selb_nxt = 1'b1;
        if (res_last && skip_r) skip_nxt = 1'b0;
      end
      ST_VA: mem_ra = la_r.idx;
      ST_VB: begin
        mem_ra = lb_r.idx;
        case (la_r.kind)
          LOC_REG: a_nxt = gp_rd;
          LOC_MEM: a_nxt = mem_q;
          LOC_SP:  a_nxt = sp_r;
          LOC_PC:  a_nxt = pc_r;
          LOC_O:   a_nxt = ovf_r;
          default: a_nxt = la_r.idx;
        endcase
      end
      // operation
      ST_OP: begin
        wo_nxt  = 1'b0;
        res_nxt = 16'd0;
        o_nxt   = 16'd0;
        case (op_r)
          OP_NB: begin
            if (ac_r == NB_JSR) begin
              sp_nxt  = sp_r - 16'd1;
              mem_we  = 1'b1;
              mem_wa  = sp_r - 16'd1;
              mem_wd  = pc_r;
              pc_nxt  = b_val;
              cyc_nxt = cyc_r + 3'd2;
            end else begin
              cyc_nxt = cyc_r + 3'd1;
              if (ac_r == NB_SYS) begin
                if (b_val == 16'd0) halt_nxt = 1'b1;
                else bad_nxt = 1'b1;
              end
            end
          end
          OP_SET: begin res_nxt = b_val; cyc_nxt = cyc_r + 3'd1; end
          OP_ADD: begin
            res_nxt = sum[15:0]; o_nxt = {15'd0, sum[16]}; wo_nxt = 1'b1;
            cyc_nxt = cyc_r + 3'd2;
          end
          OP_SUB: begin
            res_nxt = a_r - b_val; o_nxt = (a_r < b_val) ? 16'hffff : 16'd0;
            wo_nxt = 1'b1; cyc_nxt = cyc_r + 3'd2;
          end
          OP_MUL: begin
            res_nxt = prod[15:0]; o_nxt = prod[31:16]; wo_nxt = 1'b1;
            cyc_nxt = cyc_r + 3'd2;
          end
          OP_DIV, OP_MOD: begin
            wo_nxt   = (op_r == OP_DIV);
            cyc_nxt  = cyc_r + 3'd3;
            rem_nxt  = 17'd0;
            quo_nxt  = (op_r == OP_DIV) ? {a_r, 16'd0} : {16'd0, a_r};
            dvs_nxt  = b_val;
            dcnt_nxt = 5'd0;
          end
          OP_SHL: begin
            res_nxt = big ? 16'd0 : shl[15:0];
            o_nxt   = big ? 16'd0 : shl[31:16];
            wo_nxt  = 1'b1; cyc_nxt = cyc_r + 3'd2;
          end
          OP_SHR: begin
            res_nxt = big ? 16'd0 : shr[31:16];
            o_nxt   = big ? 16'd0 : shr[15:0];
            wo_nxt  = 1'b1; cyc_nxt = cyc_r + 3'd2;
          end
          OP_AND: begin res_nxt = a_r & b_val; cyc_nxt = cyc_r + 3'd1; end
          OP_BOR: begin res_nxt = a_r | b_val; cyc_nxt = cyc_r + 3'd1; end
          OP_XOR: begin res_nxt = a_r ^ b_val; cyc_nxt = cyc_r + 3'd1; end
          default: begin
            if (op_r == OP_IFE) t = (a_r == b_val);
            else if (op_r == OP_IFN) t = (a_r != b_val);
            else if (op_r == OP_IFG) t = (a_r > b_val);
            else t = ((a_r & b_val) != 16'd0);
            skip_nxt = !t;
            cyc_nxt  = cyc_r + (t ? 3'd3 : 3'd2);
          end
        endcase
      end
      // one quotient bit per cycle
      ST_DIV: begin
        dcnt_nxt = dcnt_r + 5'd1;
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_nxt = rem_sh - {1'b0, dvs_r};
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        if (dcnt_r == 5'd31) begin
          if (op_r == OP_DIV) begin
            res_nxt = quo_nxt[31:16];
            o_nxt   = quo_nxt[15:0];
          end else begin
            res_nxt = rem_nxt[15:0];
          end
        end
      end
      // write back result, then overflow
      ST_WB: begin
        mem_wa = la_r.idx;
        mem_wd = res_r;
        gp_wa  = la_r.idx[2:0];
        gp_wd  = res_r;
        case (la_r.kind)
          LOC_REG: gp_we  = 1'b1;
          LOC_MEM: mem_we = 1'b1;
          LOC_SP:  sp_nxt = res_r;
          LOC_PC:  pc_nxt = res_r;
          LOC_O:   ovf_nxt = res_r;
          default: ;
        endcase
        if (wo_r) ovf_nxt = o_r;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    out_valid              = (state_r == ST_DONE);
    out_item.read_data     = rd_r;
    out_item.prog_counter  = pc_r;
    out_item.stack_ptr     = sp_r;
    out_item.overflow_word = ovf_r;
    out_item.halted        = halt_r;
    out_item.will_skip     = skip_r;
    out_item.cycles_used   = cyc_r;
    out_item.bad_syscall   = bad_r;
  end

  // control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r    <= 16'd0;
      pc_r    <= 16'd0;
      ovf_r   <= 16'd0;
      skip_r  <= 1'b0;
      halt_r  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        gp_r[i] <= 16'd0;
      end
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      ovf_r   <= ovf_nxt;
      skip_r  <= skip_nxt;
      halt_r  <= halt_nxt;
      if (gp_we) begin
        gp_r[gp_wa] <= gp_wd;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    bad_r  <= bad_nxt;  cyc_r  <= cyc_nxt;  rd_r   <= rd_nxt;  it_r <= it_nxt;
    op_r   <= op_nxt;   ac_r   <= ac_nxt;   bc_r   <= bc_nxt;  selb_r <= selb_nxt;
    la_r   <= la_nxt;   lb_r   <= lb_nxt;   a_r    <= a_nxt;   res_r <= res_nxt;
    o_r    <= o_nxt;    wo_r   <= wo_nxt;   rem_r  <= rem_nxt; quo_r <= quo_nxt;
    dvs_r  <= dvs_nxt;  dcnt_r <= dcnt_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/word_cpu_instruction_step_top.sv -----
// ----------------------------------------------------------------------------
// word_cpu_instruction_step_top
// 16-bit word cpu core driven by host commands.
// ----------------------------------------------------------------------------
// Usage
//   A command transfer happens when start is high and busy is low. Commands
//   write or read a ram word, write or read a register, or execute one
//   instruction at pc. Each command yields one result: out_valid is high for
//   exactly one cycle with out_item; the receiver cannot stall it.
//   A two-entry queue holds commands while the core works, so busy rises only
//   once two commands are waiting. The core works on one command at a time.
// Command flow, from the transfer to the result
//   ram write and register commands pass idle and done, a ram read also
//   memrd. execute reads and splits the instruction word, resolves each
//   operand, fetching its extra word if it has one, reads the operands,
//   runs the operation, writes back (not for JSR, SYS and the IF forms)
//   and gives the result. A skipped instruction ends once its operands
//   are resolved. DIV and MOD with a nonzero divisor also pass through
//   the bit-serial divider. A waiting command is taken on return to idle.
// Reset
//   rst_n low clears registers, sp, pc, overflow, the halt and skip flags
//   and empties the queue; ram contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module word_cpu_instruction_step_top
  import wcis_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  q_ctl_t   q_ctl;
  in_item_t q_item;
  logic     q_pop;

  // command intake
  wcis_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_item(in_item),
    .q_pop  (q_pop),
    .q_ctl  (q_ctl),
    .q_item (q_item)
  );

  // execution
  wcis_back #(
    .MEM_WORDS(MEM_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_ctl    (q_ctl),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
